>>> sv/gbf_pkg.sv
// ----------------------------------------------------------------------------
// gbf_pkg: shared types and constants for the backlight fader
// Operation codes, register indexes, level limits, gamma table, status struct.
// ----------------------------------------------------------------------------
`default_nettype none

package gbf_pkg;

    localparam int FADE_STEPS_DEFAULT = 24;
    localparam int LEVEL_MAX          = 100;
    localparam int LEVEL_RESET        = 100;
    localparam int MIN_PERCENT_RESET  = 5;

    // register index = paddr[2]
    localparam logic [0:0] REG_MIN_PERCENT = 1'b0;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FADE = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    // state reported with every result item
    typedef struct packed {
        logic       started;
        logic [6:0] level;
        logic       fading;
    } t_status;

    // round(255 * (p/100)^2.2), nonzero levels at least 1
    localparam logic [7:0] GAMMA_ROM [0:100] = '{
          8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
          8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,
          8'd7,   8'd8,   8'd9,  8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd17,
         8'd18,  8'd19,  8'd21,  8'd22,  8'd24,  8'd25,  8'd27,  8'd29,  8'd30,  8'd32,
         8'd34,  8'd36,  8'd38,  8'd40,  8'd42,  8'd44,  8'd46,  8'd48,  8'd51,  8'd53,
         8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,  8'd71,  8'd74,  8'd77,  8'd80,
         8'd83,  8'd86,  8'd89,  8'd92,  8'd96,  8'd99, 8'd102, 8'd106, 8'd109, 8'd113,
        8'd116, 8'd120, 8'd124, 8'd128, 8'd131, 8'd135, 8'd139, 8'd143, 8'd148, 8'd152,
        8'd156, 8'd160, 8'd165, 8'd169, 8'd174, 8'd178, 8'd183, 8'd188, 8'd192, 8'd197,
        8'd202, 8'd207, 8'd212, 8'd217, 8'd223, 8'd228, 8'd233, 8'd238, 8'd244, 8'd249,
        8'd255
    };

    // raise nonzero levels to the minimum, then clamp to full scale
    function automatic logic [6:0] limit_level(input logic [7:0] p, input logic [6:0] min_p);
        logic [7:0] v;
        v = p;
        if (v != 8'd0 && v < {1'b0, min_p}) begin
            v = {1'b0, min_p};
        end
        if (v > 8'(LEVEL_MAX)) begin
            v = 8'(LEVEL_MAX);
        end
        return v[6:0];
    endfunction

    function automatic logic [7:0] gamma_duty(input logic [6:0] lvl);
        logic [6:0] idx;
        idx = (lvl > 7'(LEVEL_MAX)) ? 7'(LEVEL_MAX) : lvl;
        return GAMMA_ROM[idx];
    endfunction

endpackage

`default_nettype wire

>>> sv/gbf_step_unit.sv
// ----------------------------------------------------------------------------
// gbf_step_unit: level and fade state update
// Holds the fade state and computes the next state for one accepted item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbf_step_unit
    import gbf_pkg::*;
#(
    parameter int FADE_STEPS = FADE_STEPS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_target_percent,
    input  wire logic [15:0] i_fade_duration_ms,
    input  wire logic [6:0]  i_min_percent,
    output t_status          o_next
);

    localparam int StepW     = $clog2(FADE_STEPS + 1);
    localparam int RemW      = StepW;
    localparam int TickW     = $clog2(65535 / FADE_STEPS + 1);
    localparam int Lg        = $clog2(FADE_STEPS);
    // exact reciprocal: floor(x/N) = (x*M) >> S for x < 2^W, S = W + clog2(N)
    localparam int DiffShift = 7 + Lg;
    localparam int DiffMul   = (2**DiffShift + FADE_STEPS - 1) / FADE_STEPS;
    localparam int DiffProdW = DiffShift + 7;
    localparam int DurShift  = 16 + Lg;
    localparam int DurMul    = (2**DurShift + FADE_STEPS - 1) / FADE_STEPS;
    localparam int DurProdW  = DurShift + TickW;

    logic             r_started, n_started;
    logic [6:0]       r_level,   n_level;
    logic             r_fading,  n_fading;
    logic [6:0]       r_from,    n_from;
    logic [6:0]       r_to,      n_to;
    logic             r_up,      n_up;
    logic [6:0]       r_dq,      n_dq;
    logic [RemW-1:0]  r_dr,      n_dr;
    logic [6:0]       r_q,       n_q;
    logic [RemW-1:0]  r_rem,     n_rem;
    logic [StepW-1:0] r_step,    n_step;
    logic [TickW-1:0] r_ticks,   n_ticks;
    logic [TickW-1:0] r_cd,      n_cd;

    // fade start terms
    logic [6:0]          cur_level;
    logic [6:0]          to_level;
    logic                up;
    logic [6:0]          mag;
    logic [DiffProdW-1:0] diff_prod;
    logic [6:0]          dq;
    logic [6:0]          dq_times_n;
    logic [RemW-1:0]     dr;
    logic [DurProdW-1:0] dur_prod;
    logic [TickW-1:0]    ticks_q;
    logic [TickW-1:0]    ticks_new;
    logic [6:0]          first_v;

    // tick terms
    logic [RemW:0]       rem_sum;
    logic                carry;
    logic [RemW-1:0]     rem_next;
    logic [6:0]          q_next;
    logic [6:0]          step_v;
    logic [TickW-1:0]    cd_dec;

    always_comb begin
        cur_level  = r_started ? r_level : 7'd0;
        to_level   = limit_level(i_target_percent, i_min_percent);
        up         = to_level > cur_level;
        mag        = up ? (to_level - cur_level) : (cur_level - to_level);
        diff_prod  = DiffProdW'(mag) * DiffProdW'(DiffMul);
        dq         = diff_prod[DiffShift +: 7];
        dq_times_n = 7'(dq * 7'(FADE_STEPS));
        dr         = RemW'(mag - dq_times_n);
        dur_prod   = DurProdW'(i_fade_duration_ms) * DurProdW'(DurMul);
        ticks_q    = dur_prod[DurShift +: TickW];
        ticks_new  = (ticks_q == '0) ? TickW'(1) : ticks_q;
        first_v    = up ? (cur_level + dq) : (cur_level - dq);

        rem_sum  = {1'b0, r_rem} + {1'b0, r_dr};
        carry    = rem_sum >= (RemW+1)'(FADE_STEPS);
        rem_next = carry ? RemW'(rem_sum - (RemW+1)'(FADE_STEPS)) : rem_sum[RemW-1:0];
        q_next   = r_q + r_dq + 7'(carry);
        step_v   = r_up ? (r_from + q_next) : (r_from - q_next);
        cd_dec   = (r_cd != '0) ? (r_cd - TickW'(1)) : '0;
    end

    always_comb begin
        n_started = r_started;
        n_level   = r_level;
        n_fading  = r_fading;
        n_from    = r_from;
        n_to      = r_to;
        n_up      = r_up;
        n_dq      = r_dq;
        n_dr      = r_dr;
        n_q       = r_q;
        n_rem     = r_rem;
        n_step    = r_step;
        n_ticks   = r_ticks;
        n_cd      = r_cd;
        if (i_accept) begin
            case (i_operation)
                OP_SET: begin
                    n_started = 1'b1;
                    n_fading  = 1'b0;
                    n_level   = to_level;
                end
                OP_FADE: begin
                    n_started = 1'b1;
                    if (to_level == cur_level) begin
                        n_level  = cur_level;
                        n_fading = 1'b0;
                    end else begin
                        n_from   = cur_level;
                        n_to     = to_level;
                        n_up     = up;
                        n_dq     = dq;
                        n_dr     = dr;
                        n_q      = dq;
                        n_rem    = dr;
                        n_step   = StepW'(1);
                        n_ticks  = ticks_new;
                        n_cd     = ticks_new;
                        n_fading = 1'b1;
                        n_level  = limit_level({1'b0, first_v}, i_min_percent);
                    end
                end
                OP_TICK: begin
                    if (r_fading) begin
                        n_cd = cd_dec;
                        if (cd_dec == '0) begin
                            if (r_step >= StepW'(FADE_STEPS)) begin
                                n_fading = 1'b0;
                                n_level  = r_to;
                            end else begin
                                n_step  = r_step + StepW'(1);
                                n_q     = q_next;
                                n_rem   = rem_next;
                                n_level = limit_level({1'b0, step_v}, i_min_percent);
                                n_cd    = r_ticks;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_level   <= 7'(LEVEL_RESET);
            r_fading  <= 1'b0;
        end else begin
            r_started <= n_started;
            r_level   <= n_level;
            r_fading  <= n_fading;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from  <= n_from;
        r_to    <= n_to;
        r_up    <= n_up;
        r_dq    <= n_dq;
        r_dr    <= n_dr;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_ticks <= n_ticks;
        r_cd    <= n_cd;
    end

    assign o_next = '{started: n_started, level: n_level, fading: n_fading};

endmodule

`default_nettype wire

>>> sv/gamma_backlight_fader.sv
// ----------------------------------------------------------------------------
// gamma_backlight_fader: gamma-corrected backlight dimmer with linear fade
// Set, fade and millisecond-tick items in; duty, level and fade flag out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one item per cycle: set level,
//   start fade, or a 1 ms tick (the host sends ticks as items). Each item
//   yields exactly one result item on the output channel (o_valid/i_ready)
//   carrying the state after that update.
//   The result is valid in the cycle after the input item is accepted.
//   Throughput: one item per cycle; the state update is a single registered
//   pass (two constant-reciprocal multiplies in parallel, clamp, add).
//   The gamma table is read from the result register, so duty is a table
//   lookup on the registered level.
//   Stall: a result waiting in the output register does not block the input
//   as long as the receiver takes it in the same cycle; o_ready drops only
//   while the output register is full and i_ready is low.
//   Reset: output register empty, min_percent = 5, level 100, not started
//   (duty 0), no fade running.
//   Config: APB write to address 0 sets min_percent; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module gamma_backlight_fader
    import gbf_pkg::*;
#(
    parameter int FADE_STEPS = FADE_STEPS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_target_percent,
    input  wire logic [15:0] i_fade_duration_ms,
    // result items
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_duty,
    output logic [6:0]       o_level_percent,
    output logic             o_fade_active,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       in_accept;
    logic       cfg_write;
    logic [6:0] r_min_percent, n_min_percent;
    logic       r_out_valid,   n_out_valid;
    t_status    r_out,         n_out;
    t_status    step_next;

    // output register empty, or being drained this cycle
    assign o_ready   = !r_out_valid || i_ready;
    assign in_accept = i_valid && o_ready;

    // --- configuration ------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_min_percent = r_min_percent;
        if (cfg_write && paddr[2] == REG_MIN_PERCENT) begin
            n_min_percent = pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == REG_MIN_PERCENT) ? {25'd0, r_min_percent} : 32'd0;

    // --- state update -------------------------------------------------------
    gbf_step_unit #(
        .FADE_STEPS (FADE_STEPS)
    ) u_step (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_operation        (i_operation),
        .i_target_percent   (i_target_percent),
        .i_fade_duration_ms (i_fade_duration_ms),
        .i_min_percent      (r_min_percent),
        .o_next             (step_next)
    );

    // --- result register ----------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (in_accept) begin
            n_out_valid = 1'b1;
            n_out       = step_next;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_min_percent <= 7'(MIN_PERCENT_RESET);
        end else begin
            r_out_valid   <= n_out_valid;
            r_min_percent <= n_min_percent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid         = r_out_valid;
    assign o_duty          = r_out.started ? gamma_duty(r_out.level) : 8'd0;
    assign o_level_percent = r_out.level;
    assign o_fade_active   = r_out.fading;

    // --- checks -------------------------------------------------------------
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_valid)
        else $error("accepted item produced no result");

    a_fade_implies_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fade_active) |-> r_out.started)
        else $error("fade active before start");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level_percent <= 7'(LEVEL_MAX)))
        else $error("level above full scale");

    a_nonzero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out.started && o_level_percent != 7'd0) |-> (o_duty != 8'd0))
        else $error("nonzero level gave zero duty");

endmodule

`default_nettype wire
